FILE: hdl/nbme_pkg.sv
package nbme_pkg;

    localparam int unsigned BATCH_DEPTH = 4;
    localparam int unsigned IDX_W       = $clog2(BATCH_DEPTH);
    localparam int unsigned CNT_W       = $clog2(BATCH_DEPTH + 1);

    localparam logic [7:0] C_ADDR_LO   = 8'hC0;
    localparam logic [7:0] C_ADDR_HI   = 8'hE0;
    localparam logic [7:0] C_POLL      = 8'h10;
    localparam logic [7:0] C_SHORT     = 8'hD0;
    localparam logic [7:0] C_LONG      = 8'h80;
    localparam logic [7:0] C_TX_DATA   = 8'h90;
    localparam logic [7:0] C_RX_DATA   = 8'hA0;
    localparam logic [7:0] C_PARITY    = 8'hB0;
    localparam logic [7:0] C_LO_MASK   = 8'h0F;
    localparam logic [7:0] C_HI_MASK   = 8'hF0;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic {
        RES_TX     = 1'b0,
        RES_FINISH = 1'b1
    } res_kind_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_REPLY = 5'b00010,
        PH_PAR1  = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_PAR2  = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  module_address;
        logic [15:0] send_data;
        logic        poll_only;
        logic [7:0]  retry_count;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        res_kind_t   result_kind;
        logic [7:0]  tx_byte;
        logic        flush_before;
        logic        backoff_before;
        logic        success;
        logic        has_type_data;
        logic [3:0]  module_type;
        logic [15:0] response_data;
    } result_t;

    typedef struct packed {
        result_t [BATCH_DEPTH-1:0] res;
        logic [CNT_W-1:0]          cnt;
    } batch_t;

endpackage

FILE: hdl/nbme_seq.sv
module nbme_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  nbme_pkg::item_t item,
    output nbme_pkg::batch_t batch
);

    nbme_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  saved_address_reg, saved_address_next;
    logic [15:0] saved_data_reg, saved_data_next;
    logic        saved_poll_reg, saved_poll_next;
    logic [7:0]  retries_reg, retries_next;
    logic [3:0]  tx_parity_reg, tx_parity_next;
    logic [3:0]  type_nibble_reg, type_nibble_next;
    logic        first_ok_reg, first_ok_next;
    logic [15:0] rx_data_reg, rx_data_next;
    logic [3:0]  rx_parity_reg, rx_parity_next;
    logic        format_ok_reg, format_ok_next;
    logic [1:0]  nibble_idx_reg, nibble_idx_next;

    logic [7:0]  sb0, sb1, reply, rx;
    logic [3:0]  rx_lo, par_acc;
    logic        do_fail, pre;
    nbme_pkg::result_t fa0, fa1;
    logic [nbme_pkg::CNT_W-1:0] fail_n;

    function automatic logic [7:0] addr_b0(input logic [7:0] addr);
        addr_b0 = nbme_pkg::C_ADDR_LO | {4'h0, addr[3:0]};
    endfunction

    function automatic logic [7:0] addr_b1(input logic [7:0] addr, input logic poll);
        addr_b1 = nbme_pkg::C_ADDR_HI | {4'h0, addr[7:4]} | (poll ? nbme_pkg::C_POLL : 8'h00);
    endfunction

    function automatic nbme_pkg::result_t mk_tx(input logic [7:0] b, input logic fl,
                                                input logic bo);
        nbme_pkg::result_t r;
        r                = '0;
        r.result_kind    = nbme_pkg::RES_TX;
        r.tx_byte        = b;
        r.flush_before   = fl;
        r.backoff_before = bo;
        mk_tx = r;
    endfunction

    function automatic nbme_pkg::result_t mk_fin(input logic ok, input logic htd,
                                                 input logic [3:0] ty, input logic [15:0] d);
        nbme_pkg::result_t r;
        r               = '0;
        r.result_kind   = nbme_pkg::RES_FINISH;
        r.success       = ok;
        r.has_type_data = htd;
        r.module_type   = ty;
        r.response_data = d;
        mk_fin = r;
    endfunction

    assign rx    = item.rx_byte;
    assign rx_lo = rx[3:0];
    assign sb0   = addr_b0(saved_address_reg);
    assign sb1   = addr_b1(saved_address_reg, saved_poll_reg);
    assign reply = nbme_pkg::C_PARITY | {4'h0, rx_parity_reg};

    always_comb
    begin
        if (retries_reg != 8'd0)
        begin
            fa0    = mk_tx(sb0, 1'b1, 1'b0);
            fail_n = nbme_pkg::CNT_W'(2);
        end
        else
        begin
            fa0    = mk_fin(1'b0, 1'b0, 4'h0, 16'h0000);
            fail_n = nbme_pkg::CNT_W'(1);
        end
        fa1 = mk_tx(sb1, 1'b0, 1'b0);
    end

    always_comb
    begin
        phase_next         = phase_reg;
        saved_address_next = saved_address_reg;
        saved_data_next    = saved_data_reg;
        saved_poll_next    = saved_poll_reg;
        retries_next       = retries_reg;
        tx_parity_next     = tx_parity_reg;
        type_nibble_next   = type_nibble_reg;
        first_ok_next      = first_ok_reg;
        rx_data_next       = rx_data_reg;
        rx_parity_next     = rx_parity_reg;
        format_ok_next     = format_ok_reg;
        nibble_idx_next    = nibble_idx_reg;
        batch              = '0;
        do_fail            = 1'b0;
        pre                = 1'b0;
        par_acc            = tx_parity_reg ^ rx_lo ^ item.send_data[3:0] ^ item.send_data[7:4]
                             ^ item.send_data[11:8] ^ item.send_data[15:12];

        case (item.kind)
            nbme_pkg::KIND_START:
            begin
                if (phase_reg == nbme_pkg::PH_IDLE)
                begin
                    saved_address_next = item.module_address;
                    saved_data_next    = item.send_data;
                    saved_poll_next    = item.poll_only;
                    retries_next       = item.retry_count;
                    tx_parity_next     = item.module_address[3:0] ^ item.module_address[7:4];
                    batch.res[0]       = mk_tx(addr_b0(item.module_address), 1'b1, 1'b0);
                    batch.res[1]       = mk_tx(addr_b1(item.module_address, item.poll_only),
                                               1'b0, 1'b0);
                    batch.cnt          = nbme_pkg::CNT_W'(2);
                    phase_next         = nbme_pkg::PH_REPLY;
                end
            end
            nbme_pkg::KIND_TIMEOUT:
            begin
                if (phase_reg != nbme_pkg::PH_IDLE)
                begin
                    do_fail = 1'b1;
                end
            end
            nbme_pkg::KIND_BYTE:
            begin
                case (phase_reg)
                    nbme_pkg::PH_REPLY:
                    begin
                        if ((rx & nbme_pkg::C_HI_MASK) == nbme_pkg::C_SHORT)
                        begin
                            if (rx_lo == tx_parity_reg)
                            begin
                                batch.res[0] = mk_fin(1'b1, 1'b0, 4'h0, 16'h0000);
                                batch.cnt    = nbme_pkg::CNT_W'(1);
                                phase_next   = nbme_pkg::PH_IDLE;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                            end
                        end
                        else if ((rx & nbme_pkg::C_HI_MASK) == nbme_pkg::C_LONG)
                        begin
                            type_nibble_next = rx_lo;
                            for (int i = 0; i < 4; i++)
                            begin
                                batch.res[i] = mk_tx(nbme_pkg::C_TX_DATA
                                                     | {4'h0, saved_data_reg[i*4 +: 4]},
                                                     1'b0, i == 0);
                            end
                            par_acc        = tx_parity_reg ^ rx_lo ^ saved_data_reg[3:0]
                                             ^ saved_data_reg[7:4] ^ saved_data_reg[11:8]
                                             ^ saved_data_reg[15:12];
                            tx_parity_next = par_acc;
                            batch.cnt      = nbme_pkg::CNT_W'(4);
                            phase_next     = nbme_pkg::PH_PAR1;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    nbme_pkg::PH_PAR1:
                    begin
                        first_ok_next   = (rx == (nbme_pkg::C_PARITY | {4'h0, tx_parity_reg}));
                        rx_data_next    = 16'h0000;
                        rx_parity_next  = 4'h0;
                        format_ok_next  = 1'b1;
                        nibble_idx_next = 2'd0;
                        phase_next      = nbme_pkg::PH_DATA;
                    end
                    nbme_pkg::PH_DATA:
                    begin
                        if ((rx & nbme_pkg::C_HI_MASK) != nbme_pkg::C_RX_DATA)
                        begin
                            format_ok_next = 1'b0;
                        end
                        rx_data_next[{nibble_idx_reg, 2'b00} +: 4] =
                            rx_data_reg[{nibble_idx_reg, 2'b00} +: 4] | rx_lo;
                        rx_parity_next = rx_parity_reg ^ rx_lo;
                        if (nibble_idx_reg == 2'd3)
                        begin
                            nibble_idx_next = 2'd0;
                            phase_next      = nbme_pkg::PH_PAR2;
                        end
                        else
                        begin
                            nibble_idx_next = nibble_idx_reg + 2'd1;
                        end
                    end
                    nbme_pkg::PH_PAR2:
                    begin
                        if (first_ok_reg && format_ok_reg && rx == reply)
                        begin
                            batch.res[0] = mk_tx(reply, 1'b0, 1'b1);
                            batch.res[1] = mk_fin(1'b1, 1'b1, type_nibble_reg, rx_data_reg);
                            batch.cnt    = nbme_pkg::CNT_W'(2);
                            phase_next   = nbme_pkg::PH_IDLE;
                        end
                        else
                        begin
                            batch.res[0] = mk_tx(reply ^ nbme_pkg::C_LO_MASK, 1'b0, 1'b1);
                            pre          = 1'b1;
                            do_fail      = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (do_fail)
        begin
            batch.res[{1'b0, pre}]         = fa0;
            batch.cnt                      = nbme_pkg::CNT_W'(pre) + fail_n;
            if (retries_reg != 8'd0)
            begin
                batch.res[{1'b0, pre} + 2'd1] = fa1;
                retries_next                  = retries_reg - 8'd1;
                tx_parity_next                = saved_address_reg[3:0] ^ saved_address_reg[7:4];
                phase_next                    = nbme_pkg::PH_REPLY;
            end
            else
            begin
                phase_next = nbme_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= nbme_pkg::PH_IDLE;
            saved_address_reg <= 8'h00;
            saved_data_reg    <= 16'h0000;
            saved_poll_reg    <= 1'b0;
            retries_reg       <= 8'h00;
            tx_parity_reg     <= 4'h0;
            type_nibble_reg   <= 4'h0;
            first_ok_reg      <= 1'b0;
            rx_data_reg       <= 16'h0000;
            rx_parity_reg     <= 4'h0;
            format_ok_reg     <= 1'b1;
            nibble_idx_reg    <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg         <= phase_next;
            saved_address_reg <= saved_address_next;
            saved_data_reg    <= saved_data_next;
            saved_poll_reg    <= saved_poll_next;
            retries_reg       <= retries_next;
            tx_parity_reg     <= tx_parity_next;
            type_nibble_reg   <= type_nibble_next;
            first_ok_reg      <= first_ok_next;
            rx_data_reg       <= rx_data_next;
            rx_parity_reg     <= rx_parity_next;
            format_ok_reg     <= format_ok_next;
            nibble_idx_reg    <= nibble_idx_next;
        end
    end

endmodule

FILE: hdl/nbme_emit.sv
module nbme_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  nbme_pkg::batch_t  batch,
    input  logic              out_ready,
    output logic              out_valid,
    output nbme_pkg::result_t out_res,
    output logic              out_last,
    output logic              free
);

    nbme_pkg::result_t [nbme_pkg::BATCH_DEPTH-1:0] res_reg;
    logic                      busy_reg;
    logic [nbme_pkg::IDX_W-1:0] idx_reg;
    logic [nbme_pkg::IDX_W-1:0] last_idx_reg;
    logic                      done;

    assign out_valid = busy_reg;
    assign out_res   = res_reg[idx_reg];
    assign out_last  = (idx_reg == last_idx_reg);
    assign done      = busy_reg && out_ready && out_last;
    assign free      = !busy_reg || done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= '0;
        end
        else if (load)
        begin
            busy_reg     <= 1'b1;
            idx_reg      <= '0;
            last_idx_reg <= nbme_pkg::IDX_W'(batch.cnt - nbme_pkg::CNT_W'(1));
        end
        else if (busy_reg && out_ready)
        begin
            if (out_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + nbme_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
    end

endmodule

FILE: hdl/nibble_bus_master_exchange_unit.sv
// Channel  Dir  tdata / tuser / tlast
// s_       in   tdata: module_address, send_data, poll_only, retry_count, rx_byte; tuser: kind
// m_       out  tdata: tx_byte, flags, module_type, response_data; tuser: result_kind; tlast
//
// An item is held in the input register, then its results (zero to four) load the
// result batch in one pass; the batch hands out one result per cycle while m_tready is high,
// and items with no result step without waiting for the batch or loading it.
// The next item is taken while a batch still drains; one with results steps once it frees.
// Reset: bus state idle, input register and batch empty. m_tready low holds the batch; an
// item with results then waits in the input register and s_tready drops.
module nibble_bus_master_exchange_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // module_address, send_data, poll_only, retry_count, rx_byte
    input  logic [1:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // tx_byte, flush_before, backoff_before, success,
                                  // has_type_data, module_type, response_data
    output logic        m_tuser,  // result_kind
    output logic        m_tlast
);

    nbme_pkg::item_t   item_reg;
    logic              in_valid_reg;
    nbme_pkg::batch_t  batch;
    nbme_pkg::result_t res;
    logic              fire, load, free;

    assign fire     = in_valid_reg && (batch.cnt == '0 || free);
    assign load     = fire && batch.cnt != '0;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind           <= nbme_pkg::kind_t'(s_tuser);
            item_reg.module_address <= s_tdata[7:0];
            item_reg.send_data      <= s_tdata[23:8];
            item_reg.poll_only      <= s_tdata[24];
            item_reg.retry_count    <= s_tdata[32:25];
            item_reg.rx_byte        <= s_tdata[40:33];
        end
    end

    nbme_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .batch (batch)
    );

    nbme_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .batch     (batch),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res),
        .out_last  (m_tlast),
        .free      (free)
    );

    assign m_tuser = res.result_kind;
    assign m_tdata = {res.response_data, res.module_type, res.has_type_data, res.success,
                      res.backoff_before, res.flush_before, res.tx_byte};

`ifndef SYNTH
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("finish item not last");

    a_type_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tdata[10] && m_tuser)
        else $error("type data without success");

    a_flush_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> !m_tuser && !m_tlast && !m_tdata[9])
        else $error("flush on wrong item");

    a_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("batch overwritten");
`endif

endmodule
